/* rtl/core/median_filter_3x3_rgb_top_assert.svh */
// Assertion macros for the 3x3 RGB median filter.
// Used by the lane and top-level files; no other dependencies.
`ifndef MEDIAN_FILTER_3X3_RGB_TOP_ASSERT_SVH
`define MEDIAN_FILTER_3X3_RGB_TOP_ASSERT_SVH
// implication checked on every edge outside reset
`define MF_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication
`define MF_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

/* rtl/core/mf3_pkg.sv */
// Package for the 3x3 RGB median filter: types and constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mf3_pkg;
  localparam int unsigned PixW  = 8;
  localparam int unsigned WinN  = 9;
  localparam int unsigned RowW  = 13;
  localparam int unsigned HLimit = 4096;

  typedef enum logic [0:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef logic [PixW-1:0] pix_t;

  // border mask and frame flag that travel with a window
  typedef struct packed {
    logic [WinN-1:0] use_m;
    logic            last;
  } win_ctl_t;
endpackage
`default_nettype wire

/* rtl/core/mf3_lane.sv */
// One channel lane: masked 9-value median by rank counting, two stages.
// Depends on mf3_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "median_filter_3x3_rgb_top_assert.svh"
module mf3_lane (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              adv,
  input  wire mf3_pkg::pix_t     win [9],
  input  wire logic [8:0]        use_m,
  output mf3_pkg::pix_t          med_r
);
  import mf3_pkg::*;

  // stage 1: rank of each value among the used cells (ties broken by index)
  logic [3:0] rank_nxt [WinN];
  logic [3:0] rank_r   [WinN];
  pix_t       val_r    [WinN];
  logic [WinN-1:0] use_r;
  logic [3:0] cnt_r;
  logic [3:0] cnt_nxt;

  always_comb begin
    cnt_nxt = '0;
    for (int i = 0; i < WinN; i++) cnt_nxt = cnt_nxt + {3'd0, use_m[i]};
    for (int i = 0; i < WinN; i++) begin
      rank_nxt[i] = '0;
      for (int j = 0; j < WinN; j++) begin
        if (j != i && use_m[j] &&
            ((win[j] < win[i]) || (win[j] == win[i] && j < i)))
          rank_nxt[i] = rank_nxt[i] + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rank_r <= rank_nxt;
      val_r  <= win;
      use_r  <= use_m;
      cnt_r  <= cnt_nxt;
    end
  end

  // stage 2: pick the value whose rank is count/2
  pix_t med_nxt;
  always_comb begin
    med_nxt = '0;
    for (int i = 0; i < WinN; i++)
      if (use_r[i] && rank_r[i] == {1'b0, cnt_r[3:1]}) med_nxt = val_r[i];
  end

  always_ff @(posedge clk) begin
    if (adv) med_r <= med_nxt;
  end

  `MF_ASSERT_IMPL(a_center_used, adv, use_m[4])
  `MF_ASSERT_IMPL(a_cnt_range, adv, (cnt_nxt >= 4'd1) && (cnt_nxt <= 4'd9))
  `MF_ASSERT_NEXT(a_hold, !adv, $stable(med_r))
endmodule
`default_nettype wire

/* rtl/core/median_filter_3x3_rgb_top.sv */
// 3x3 median filter, RGB. The result for pixel n goes with request n+width+1;
// out_valid rises once that request has passed the RAM read, window, rank, select and
// output registers. Throughput: one request per cycle; every stage stalls only while
// a result waits on out_ready. Line stores are 2 x MAX_WIDTH RAMs with registered reads,
// no clearing pass. Reset (sync, active low) clears counters, valid bits and the 3x3 window,
// sets stage 0/1 control to the idle word; width/height registers reset to 200 and 300.
`timescale 1ns / 1ps
`default_nettype none
`include "median_filter_3x3_rgb_top_assert.svh"
module median_filter_3x3_rgb_top #(
  parameter int unsigned MAX_WIDTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_action,
  input  wire logic [7:0]  in_red_in,
  input  wire logic [7:0]  in_green_in,
  input  wire logic [7:0]  in_blue_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_red_out,
  output logic [7:0]       out_green_out,
  output logic [7:0]       out_blue_out,
  output logic             out_frame_end,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [12:0] cfg_wdata
);
  import mf3_pkg::*;

  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
  // control word before the first window: center only, no frame end
  localparam win_ctl_t CtlIdle = '{use_m: 9'b0_0001_0000, last: 1'b0};

  // ---- config; counters restart on any write ----
  logic [8:0]      width_r;
  logic [RowW-1:0] height_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 9'd200;
      height_r <= 13'd300;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_WIDTH:  width_r  <= cfg_wdata[8:0];
        CFG_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // effective width / height, clamped
  logic [CW-1:0]   w_eff;
  logic [RowW-1:0] h_eff;
  always_comb begin
    if (width_r == 9'd0) w_eff = CW'(1);
    else if ({23'd0, width_r} > 32'(MAX_WIDTH)) w_eff = CW'(MAX_WIDTH);
    else w_eff = CW'(width_r);
    if (height_r == '0) h_eff = RowW'(1);
    else if (32'(height_r) > 32'(HLimit)) h_eff = RowW'(HLimit);
    else h_eff = height_r;
  end

  // ---- pipeline advance: stage 0 (RAM read), 1 (window), 2 (rank), 3 (select), 4 (out) ----
  logic s0_r, e0_r, v1_r, v2_r, v3_r, out_v_r;
  logic adv;
  assign adv      = !out_v_r || out_ready;
  assign in_ready = adv;
  assign out_valid = out_v_r;
  logic acc;
  assign acc = in_valid && in_ready;

  // ---- input counters ----
  logic [CW-1:0] in_col_r;
  logic          primed_r;  // set once width+1 items seen in this frame
  logic [CW-1:0] seen_r;    // counts the first width items
  logic [CW-1:0] in_col_nxt;
  logic [CW-1:0] col_cl;
  assign col_cl = (32'(in_col_r) >= 32'(MAX_WIDTH)) ? '0 : in_col_r;
  assign in_col_nxt = (in_col_r + CW'(1) >= w_eff) ? '0 : in_col_r + CW'(1);

  // ---- output counters ----
  logic [CW-1:0]   oc_r;
  logic [RowW-1:0] or_r;
  logic            last;
  assign last = (32'(oc_r) + 1 >= 32'(w_eff)) && (32'(or_r) + 1 >= 32'(h_eff));
  logic emit;
  assign emit = acc && primed_r;

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      in_col_r <= '0;
      seen_r   <= '0;
      primed_r <= 1'b0;
      oc_r     <= '0;
      or_r     <= '0;
    end else if (acc) begin
      in_col_r <= in_col_nxt;
      if (!primed_r) begin
        if (32'(seen_r) >= 32'(w_eff)) primed_r <= 1'b1;
        else seen_r <= seen_r + CW'(1);
      end
      if (emit) begin
        if (last) begin
          in_col_r <= '0;
          seen_r   <= '0;
          primed_r <= 1'b0;
          oc_r     <= '0;
          or_r     <= '0;
        end else if (32'(oc_r) + 1 >= 32'(w_eff)) begin
          oc_r <= '0;
          or_r <= or_r + RowW'(1);
        end else begin
          oc_r <= oc_r + CW'(1);
        end
      end
    end
  end

  // ---- line stores; a registered read, write of the same address ----
  logic [23:0] upper_mem [MAX_WIDTH];
  logic [23:0] lower_mem [MAX_WIDTH];
  logic [23:0] top_q, mid_q, dat_q;
  logic [23:0] data;
  assign data = in_action ? 24'd0 : {in_red_in, in_green_in, in_blue_in};
  logic [AW-1:0] addr;
  assign addr = col_cl[AW-1:0];

  always_ff @(posedge clk) begin
    if (acc) begin
      top_q <= upper_mem[addr];
      mid_q <= lower_mem[addr];
      upper_mem[addr] <= lower_mem[addr];
      lower_mem[addr] <= data;
      dat_q <= data;
    end
  end

  // border mask and frame flag of the result that the accepted request completes
  win_ctl_t ctl0_r, ctl1_r, ctl2_r;
  win_ctl_t ctl_nxt;
  always_comb begin
    logic rt, rb, cl, cr;
    rt = (or_r != '0);
    rb = (32'(or_r) + 1 < 32'(h_eff));
    cl = (oc_r != '0);
    cr = (32'(oc_r) + 1 < 32'(w_eff));
    ctl_nxt.use_m = {rb & cr, rb, rb & cl, cr, 1'b1, cl, rt & cr, rt, rt & cl};
    ctl_nxt.last  = last;
  end

  // stage 1 shifts the window with the column read in stage 0
  logic [23:0] win_r [9];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WinN; i++) win_r[i] <= '0;
    end else if (adv && s0_r) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r*3]   <= win_r[r*3+1];
        win_r[r*3+1] <= win_r[r*3+2];
      end
      win_r[2] <= top_q;
      win_r[5] <= mid_q;
      win_r[8] <= dat_q;
    end
  end

  // request present / result owed, and its control, through stages 0 and 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r   <= 1'b0;
      e0_r   <= 1'b0;
      v1_r   <= 1'b0;
      ctl0_r <= CtlIdle;
      ctl1_r <= CtlIdle;
    end else if (adv) begin
      s0_r   <= acc;
      e0_r   <= emit;
      v1_r   <= e0_r;
      ctl0_r <= ctl_nxt;
      ctl1_r <= ctl0_r;
    end
  end

  // lanes see the window as it stands after the shift (stage-1 register)
  pix_t wr [9], wg [9], wb [9];
  always_comb begin
    for (int i = 0; i < WinN; i++) begin
      wr[i] = win_r[i][23:16];
      wg[i] = win_r[i][15:8];
      wb[i] = win_r[i][7:0];
    end
  end

  pix_t mr, mg, mb;
  mf3_lane u_r (.clk, .rst_n, .adv, .win(wr), .use_m(ctl1_r.use_m), .med_r(mr));
  mf3_lane u_g (.clk, .rst_n, .adv, .win(wg), .use_m(ctl1_r.use_m), .med_r(mg));
  mf3_lane u_b (.clk, .rst_n, .adv, .win(wb), .use_m(ctl1_r.use_m), .med_r(mb));

  logic last3_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
      v3_r <= v2_r;
      out_v_r <= v3_r;
      ctl2_r <= ctl1_r;
      last3_r <= ctl2_r.last;
    end
  end

  // merge stage: the lanes' registered medians form one result
  always_ff @(posedge clk) begin
    if (adv) begin
      out_red_out   <= mr;
      out_green_out <= mg;
      out_blue_out  <= mb;
      out_frame_end <= last3_r;
    end
  end

  `MF_ASSERT_IMPL(a_stall_hold, out_valid && !out_ready, !in_ready)
  `MF_ASSERT_IMPL(a_col_range, 1'b1, in_col_r < w_eff)
  `MF_ASSERT_NEXT(a_hold_out, out_valid && !out_ready, out_valid)
endmodule
`default_nettype wire

/* tb/tb_median_filter_3x3_rgb_top.sv */
// Self-checking bench for the 3x3 RGB median filter: directed frames, then frames of random size and content.
// Depends on mf3_pkg and median_filter_3x3_rgb_top; the predictor lives in the class below.
`timescale 1ns / 1ps
module tb_median_filter_3x3_rgb_top;
  import mf3_pkg::*;

  localparam int MaxW       = 256;
  localparam int HeightMax  = 4096;
  localparam int DrainWait  = 12;       // cycles after the last result before a write
  localparam int CycleLimit = 1000000;
  localparam int RandItems  = 850;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       fe;
  } px_res_t;

  // Predicts the filtered stream and holds the results still owed by the block.
  class median_scoreboard;
    logic [23:0] upper_line [MaxW];
    logic [23:0] lower_line [MaxW];
    logic [23:0] win [3][3];
    int unsigned in_col, in_row, out_col, out_row;
    logic [8:0]  width_reg;
    logic [12:0] height_reg;
    px_res_t     pending_px[$];
    int          fails;

    function new();
      for (int i = 0; i < MaxW; i++) begin
        upper_line[i] = '0;
        lower_line[i] = '0;
      end
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++) win[r][c] = '0;
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      width_reg = 9'd200;
      height_reg = 13'd300;
      fails = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [12:0] val);
      if (idx == CFG_WIDTH) width_reg = val[8:0];
      else height_reg = val;
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    endfunction

    function int unsigned eff_w();
      if (width_reg == 0) return 1;
      if (width_reg > MaxW) return MaxW;
      return width_reg;
    endfunction

    function int unsigned eff_h();
      if (height_reg == 0) return 1;
      if (height_reg > HeightMax) return HeightMax;
      return height_reg;
    endfunction

    // sorted element count/2 of one channel over the in-bounds cells
    function logic [7:0] chan_median(logic [8:0] mask, int sh);
      logic [7:0] v [9];
      logic [7:0] x;
      int cnt, k;
      cnt = 0;
      for (int i = 0; i < 9; i++) begin
        if (mask[i]) begin
          x = 8'(win[i / 3][i % 3] >> sh);
          k = cnt;
          while (k > 0 && v[k-1] > x) begin
            v[k] = v[k-1];
            k--;
          end
          v[k] = x;
          cnt++;
        end
      end
      return v[cnt / 2];
    endfunction

    function void note_request(logic act, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int unsigned w, h, col, seen;
      logic [23:0] data, top, mid;
      logic [8:0]  mask;
      px_res_t     res;
      bit          ok;
      w = eff_w();
      h = eff_h();
      data = act ? 24'h0 : {r, g, b};   // flush moves the stream on as a black pixel
      col = (in_col >= MaxW) ? 0 : in_col;
      top = upper_line[col];
      mid = lower_line[col];
      upper_line[col] = mid;
      lower_line[col] = data;
      for (int i = 0; i < 3; i++) begin
        win[i][0] = win[i][1];
        win[i][1] = win[i][2];
      end
      win[0][2] = top;
      win[1][2] = mid;
      win[2][2] = data;
      seen = in_row * w + in_col;
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
      if (seen < w + 1) return;
      for (int i = 0; i < 9; i++) begin
        ok = 1;
        if (i / 3 == 0 && out_row == 0) ok = 0;
        if (i / 3 == 2 && out_row + 1 >= h) ok = 0;
        if (i % 3 == 0 && out_col == 0) ok = 0;
        if (i % 3 == 2 && out_col + 1 >= w) ok = 0;
        mask[i] = ok;
      end
      res.r = chan_median(mask, 16);
      res.g = chan_median(mask, 8);
      res.b = chan_median(mask, 0);
      res.fe = (out_col + 1 >= w) && (out_row + 1 >= h);
      pending_px.push_back(res);
      if (res.fe) begin
        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      end else begin
        out_col++;
        if (out_col >= w) begin
          out_col = 0;
          out_row++;
        end
      end
    endfunction

    function void check_result(px_res_t got);
      px_res_t want;
      if (pending_px.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending_px.pop_front();
      if (got !== want) begin
        fails++;
        if (fails <= 10)
          $display("mismatch: exp r=%h g=%h b=%h fe=%b  got r=%h g=%h b=%h fe=%b",
                   want.r, want.g, want.b, want.fe, got.r, got.g, got.b, got.fe);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_action;
  logic [7:0]  in_red_in, in_green_in, in_blue_in;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_red_out, out_green_out, out_blue_out;
  logic        out_frame_end;
  logic        cfg_we;
  logic        cfg_index;
  logic [12:0] cfg_wdata;

  median_scoreboard sb = new();
  int  cycles;
  int  out_stall;
  int  items_sent;
  bit  no_idle;       // frames with both sides running flat out
  bit  paused_once;

  median_filter_3x3_rgb_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_red_in(in_red_in), .in_green_in(in_green_in), .in_blue_in(in_blue_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_red_out(out_red_out), .out_green_out(out_green_out),
    .out_blue_out(out_blue_out), .out_frame_end(out_frame_end),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // request monitor: values seen here are the ones that were on the wires at the edge
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.note_request(in_action, in_red_in, in_green_in, in_blue_in);
  end

  // result side: check on acceptance, then draw a fresh stall for the next result
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        sb.check_result({out_red_out, out_green_out, out_blue_out, out_frame_end});
        out_stall = no_idle ? 0 : $urandom_range(0, 3);
      end else if (out_stall > 0) begin
        out_stall--;
      end
      out_ready <= (out_stall == 0);
    end
  end

  // hard stop for a hung handshake
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("[median_filter_3x3_rgb_top] ERROR");
      $finish;
    end
  end

  // one request; returns at the edge where it is taken
  task automatic send_px(logic act, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_action   <= act;
    in_red_in   <= r;
    in_green_in <= g;
    in_blue_in  <= b;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    items_sent++;
  endtask

  // sender off, all results in, then let the pipeline settle
  task automatic drain_out();
    in_valid <= 1'b0;
    while (sb.pending_px.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic write_cfg(cfg_idx_t idx, logic [12:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_chan();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // whole frame plus its flush slots; odd_pct sets how often items go off-pattern
  task automatic run_frame(logic [12:0] wv, logic [12:0] hv, int odd_pct);
    int unsigned w, h, n;
    drain_out();
    write_cfg(CFG_WIDTH, wv);
    write_cfg(CFG_HEIGHT, hv);
    w = sb.eff_w();
    h = sb.eff_h();
    n = w * h;
    for (int unsigned i = 0; i < n; i++) begin
      // hold the sender once mid-frame until the block has caught up
      if (!paused_once && n > 8 && i == n / 2) begin
        paused_once = 1;
        in_valid <= 1'b0;
        while (sb.pending_px.size() != 0) @(posedge clk);
        @(posedge clk);
      end
      if ($urandom_range(0, 99) < odd_pct)
        send_px(1'b1, pick_chan(), pick_chan(), pick_chan());  // black pixel mid-frame
      else
        send_px(1'b0, pick_chan(), pick_chan(), pick_chan());
    end
    // flush slots; a pixel here only feeds positions outside the image
    for (int unsigned i = 0; i <= w; i++) begin
      if ($urandom_range(0, 99) < odd_pct)
        send_px(1'b0, pick_chan(), pick_chan(), pick_chan());
      else
        send_px(1'b1, pick_chan(), pick_chan(), pick_chan());
    end
  endtask

  initial begin
    cycles      = 0;
    items_sent  = 0;
    no_idle     = 0;
    paused_once = 0;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_action   <= 1'b0;
    in_red_in   <= '0;
    in_green_in <= '0;
    in_blue_in  <= '0;
    cfg_we      <= 1'b0;
    cfg_index   <= CFG_WIDTH;
    cfg_wdata   <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: 3x3 with corner/edge/center counts, extreme values, black pixel mid-frame
    drain_out();
    write_cfg(CFG_WIDTH, 13'd3);
    write_cfg(CFG_HEIGHT, 13'd3);
    send_px(1'b0, 8'hff, 8'h00, 8'hff);
    send_px(1'b0, 8'h00, 8'hff, 8'h00);
    send_px(1'b0, 8'hff, 8'hff, 8'hff);
    send_px(1'b1, 8'hff, 8'hff, 8'hff);
    send_px(1'b0, 8'h80, 8'h7f, 8'h01);
    send_px(1'b0, 8'h00, 8'h00, 8'h00);
    send_px(1'b0, 8'hfe, 8'h01, 8'h55);
    send_px(1'b0, 8'haa, 8'h55, 8'hff);
    send_px(1'b0, 8'h01, 8'hfe, 8'h00);
    send_px(1'b1, 8'h00, 8'h00, 8'h00);
    send_px(1'b0, 8'hff, 8'hff, 8'hff);   // pixel in a flush slot
    send_px(1'b1, 8'h00, 8'h00, 8'h00);
    send_px(1'b1, 8'h00, 8'h00, 8'h00);
    // single-pixel image, then zero sizes that clamp to one
    run_frame(13'd1, 13'd1, 0);
    run_frame(13'd0, 13'd0, 0);

    // size extremes: clamped widest row, then a clamped height cut short by a write
    run_frame(13'd511, 13'd1, 5);
    drain_out();
    write_cfg(CFG_WIDTH, 13'd3);
    write_cfg(CFG_HEIGHT, 13'd8191);
    for (int i = 0; i < 40; i++)
      send_px(1'b0, pick_chan(), pick_chan(), pick_chan());

    // random frames, mostly small, up to the overall request budget
    while (items_sent < RandItems) begin
      no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0)
        run_frame(13'($urandom_range(1, 40)), 13'($urandom_range(1, 4)), 10);
      else
        run_frame(13'($urandom_range(1, 8)), 13'($urandom_range(1, 6)), 8);
    end
    no_idle = 0;

    drain_out();
    if (sb.fails == 0)
      $display("[median_filter_3x3_rgb_top] OK");
    else
      $display("[median_filter_3x3_rgb_top] ERROR");
    $finish;
  end
endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/mf3_pkg.sv
rtl/core/mf3_lane.sv
rtl/core/median_filter_3x3_rgb_top.sv
tb/tb_median_filter_3x3_rgb_top.sv
